// ===== rtl/core/tfp_pkg.sv =====
package tfp_pkg;

  // Character codes recognised by the parser
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Target register file: four pairs, x and y each
  localparam int PAIR_W      = 2;
  localparam int NUM_TARGETS = 8;
  localparam int TGT_IDX_W   = 3;

  // Control part of a command passed from parser to target update
  typedef struct packed {
    logic              is_clear;
    logic [PAIR_W-1:0] pair;
  } cmd_ctrl_t;

endpackage

// ===== rtl/core/tfp_queue.sv =====
module tfp_queue #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

// ===== rtl/core/tfp_front.sv =====
module tfp_front #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [7:0]                    in_rx_byte,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output tfp_pkg::cmd_ctrl_t            cmd_ctrl,
  output logic signed [VALUE_WIDTH-1:0] cmd_x,
  output logic signed [VALUE_WIDTH-1:0] cmd_y
);
  import tfp_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_GOT_E, PH_GOT_EC, PH_AFTER_LET,
    PH_X_WS, PH_X_SIGN, PH_X_DIG,
    PH_Y_WS, PH_Y_SIGN, PH_Y_DIG, PH_SKIP
  } phase_t;

  localparam logic [VALUE_WIDTH-1:0] MAG_CAP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // Decimal accumulate, saturating at the magnitude of the most negative value
  function automatic logic [VALUE_WIDTH-1:0] acc_digit(input logic [VALUE_WIDTH-1:0] mag,
                                                       input logic [3:0] dig);
    logic [VALUE_WIDTH+3:0] v;
    v = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {{VALUE_WIDTH{1'b0}}, dig};
    return (v > {4'b0000, MAG_CAP}) ? MAG_CAP : v[VALUE_WIDTH-1:0];
  endfunction

  // Sign and magnitude to two's complement, positive side clipped
  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [VALUE_WIDTH-1:0] mag,
                                                      input logic neg);
    logic [VALUE_WIDTH-1:0] r;
    if (neg) begin
      r = ~mag + 1'b1;
    end else begin
      r = (mag > POS_MAX) ? POS_MAX : mag;
    end
    return r;
  endfunction

  phase_t                 phase_r, phase_nxt;
  logic [PAIR_W-1:0]      pair_r, pair_nxt;
  logic [VALUE_WIDTH-1:0] x_mag_r, x_mag_nxt, y_mag_r, y_mag_nxt;
  logic                   x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt;
  logic                   done_r, done_nxt;

  logic [7:0] c;
  logic       is_letter, is_ws, is_digit, is_sign, is_minus;
  logic       accept, in_frame, frame_end, frame_ok;
  logic [3:0] dig;

  // Character classes
  assign c         = in_rx_byte;
  assign is_letter = (c >= CH_A) && (c <= CH_D);
  assign is_ws     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_digit  = (c >= CH_0) && (c <= CH_9);
  assign is_minus  = (c == CH_MINUS);
  assign is_sign   = (c == CH_PLUS) || is_minus;
  assign dig       = c[3:0];

  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign in_frame  = !((phase_r == PH_HUNT) || (phase_r == PH_GOT_E) || (phase_r == PH_GOT_EC));
  assign frame_end = !in_mode && in_frame && (c == CH_P);
  assign frame_ok  = done_r || (phase_r == PH_Y_DIG);

  // Command towards the target update
  assign cmd_valid         = accept && (in_mode || (frame_end && frame_ok));
  assign cmd_ctrl.is_clear = in_mode;
  assign cmd_ctrl.pair     = in_mode ? '0 : pair_r;
  assign cmd_x             = to_value(x_mag_r, x_neg_r);
  assign cmd_y             = to_value(y_mag_r, y_neg_r);

  // Parser next state
  always_comb begin
    phase_nxt = phase_r;
    pair_nxt  = pair_r;
    x_mag_nxt = x_mag_r;
    x_neg_nxt = x_neg_r;
    y_mag_nxt = y_mag_r;
    y_neg_nxt = y_neg_r;
    done_nxt  = done_r;
    if (accept && !in_mode) begin
      if (frame_end) begin
        phase_nxt = PH_HUNT;
        done_nxt  = 1'b0;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            phase_nxt = (c == CH_E) ? PH_GOT_E : PH_HUNT;
          end
          PH_GOT_E, PH_GOT_EC: begin
            if (is_letter) begin
              pair_nxt  = c[1:0] - 2'd1;
              x_mag_nxt = '0;
              x_neg_nxt = 1'b0;
              y_mag_nxt = '0;
              y_neg_nxt = 1'b0;
              done_nxt  = 1'b0;
              phase_nxt = PH_AFTER_LET;
            end else if ((phase_r == PH_GOT_E) && (c == CH_COMMA)) begin
              phase_nxt = PH_GOT_EC;
            end else begin
              phase_nxt = (c == CH_E) ? PH_GOT_E : PH_HUNT;
            end
          end
          PH_AFTER_LET, PH_X_WS: begin
            if (((phase_r == PH_AFTER_LET) && (c == CH_COMMA)) || is_ws) begin
              phase_nxt = PH_X_WS;
            end else if (is_sign) begin
              x_neg_nxt = is_minus;
              phase_nxt = PH_X_SIGN;
            end else if (is_digit) begin
              x_mag_nxt = acc_digit('0, dig);
              phase_nxt = PH_X_DIG;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_X_SIGN: begin
            if (is_digit) begin
              x_mag_nxt = acc_digit('0, dig);
              phase_nxt = PH_X_DIG;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_X_DIG: begin
            if (is_digit) begin
              x_mag_nxt = acc_digit(x_mag_r, dig);
            end else begin
              phase_nxt = (c == CH_COMMA) ? PH_Y_WS : PH_SKIP;
            end
          end
          PH_Y_WS: begin
            if (is_ws) begin
              phase_nxt = PH_Y_WS;
            end else if (is_sign) begin
              y_neg_nxt = is_minus;
              phase_nxt = PH_Y_SIGN;
            end else if (is_digit) begin
              y_mag_nxt = acc_digit('0, dig);
              phase_nxt = PH_Y_DIG;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_Y_SIGN: begin
            if (is_digit) begin
              y_mag_nxt = acc_digit('0, dig);
              phase_nxt = PH_Y_DIG;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_Y_DIG: begin
            if (is_digit) begin
              y_mag_nxt = acc_digit(y_mag_r, dig);
            end else begin
              done_nxt  = 1'b1;
              phase_nxt = PH_SKIP;
            end
          end
          PH_SKIP: begin
            phase_nxt = PH_SKIP;
          end
          default: begin
            phase_nxt = PH_HUNT;
            done_nxt  = 1'b0;
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pair_r  <= '0;
      x_mag_r <= '0;
      x_neg_r <= 1'b0;
      y_mag_r <= '0;
      y_neg_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pair_r  <= pair_nxt;
      x_mag_r <= x_mag_nxt;
      x_neg_r <= x_neg_nxt;
      y_mag_r <= y_mag_nxt;
      y_neg_r <= y_neg_nxt;
      done_r  <= done_nxt;
    end
  end

  a_frame_on_p: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && !cmd_ctrl.is_clear) |-> (in_rx_byte == CH_P))
    else $error("frame command without closing P");

  a_mag_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (x_mag_r <= MAG_CAP) && (y_mag_r <= MAG_CAP))
    else $error("magnitude beyond saturation cap");

  a_p_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |=> (phase_r == PH_HUNT) && !done_r)
    else $error("parser not hunting after frame end");

endmodule

// ===== rtl/core/tfp_back.sv =====
module tfp_back #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  tfp_pkg::cmd_ctrl_t                   cmd_ctrl,
  input  logic signed [VALUE_WIDTH-1:0]        cmd_x,
  input  logic signed [VALUE_WIDTH-1:0]        cmd_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_was_clear,
  output logic [tfp_pkg::PAIR_W-1:0]           out_updated_pair,
  output logic signed [VALUE_WIDTH-1:0]        out_targets [tfp_pkg::NUM_TARGETS]
);
  import tfp_pkg::*;

  logic signed [VALUE_WIDTH-1:0] tgt_r   [NUM_TARGETS];
  logic signed [VALUE_WIDTH-1:0] tgt_nxt [NUM_TARGETS];
  logic                          out_valid_r, was_clear_r;
  logic [PAIR_W-1:0]             pair_r;
  logic                          pop;

  // Targets only change when a new word is loaded, so they double as the output
  assign cmd_ready        = !out_valid_r || out_ready;
  assign pop              = cmd_valid && cmd_ready;
  assign out_valid        = out_valid_r;
  assign out_was_clear    = was_clear_r;
  assign out_updated_pair = pair_r;
  assign out_targets      = tgt_r;

  // Target update for the command at the head of the queue
  always_comb begin
    for (int k = 0; k < NUM_TARGETS; k++) begin
      if (cmd_ctrl.is_clear) begin
        tgt_nxt[k] = '0;
      end else if (TGT_IDX_W'(k) == {cmd_ctrl.pair, 1'b0}) begin
        tgt_nxt[k] = cmd_x;
      end else if (TGT_IDX_W'(k) == {cmd_ctrl.pair, 1'b1}) begin
        tgt_nxt[k] = cmd_y;
      end else begin
        tgt_nxt[k] = tgt_r[k];
      end
    end
  end

  // Target file and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      was_clear_r <= 1'b0;
      pair_r      <= '0;
      for (int k = 0; k < NUM_TARGETS; k++) begin
        tgt_r[k] <= '0;
      end
    end else if (pop) begin
      out_valid_r <= 1'b1;
      was_clear_r <= cmd_ctrl.is_clear;
      pair_r      <= cmd_ctrl.pair;
      tgt_r       <= tgt_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd_ctrl.is_clear) |=>
      (tgt_r[0] == '0) && (tgt_r[3] == '0) && (tgt_r[7] == '0) && was_clear_r)
    else $error("targets not cleared");

  a_frame_write: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !cmd_ctrl.is_clear) |=>
      (tgt_r[{pair_r, 1'b0}] == $past(cmd_x)) && (tgt_r[{pair_r, 1'b1}] == $past(cmd_y)))
    else $error("frame values not stored in their pair");

  a_clear_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && was_clear_r) |-> (pair_r == '0))
    else $error("clear word with nonzero pair");

endmodule

// ===== rtl/core/target_frame_parser.sv =====
// Channel | Direction | Words                       | Handshake
// in_     | input     | in_mode, in_rx_byte         | in_valid / in_ready
// out_    | output    | was_clear, pair, 8 targets  | out_valid / out_ready
//
// One byte per cycle is accepted while the command queue has room; a result passes
// through the command queue and then into the output register.
// A 2-word command queue sits between the parser and the target file, so the
// parser keeps taking bytes while a result waits; in_ready drops only when it is full.
// Synchronous active-low reset puts the parser in hunt and zeroes all targets.
module target_frame_parser #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_was_clear,
  output logic [1:0]                    out_updated_pair,
  output logic signed [VALUE_WIDTH-1:0] out_target_a_x,
  output logic signed [VALUE_WIDTH-1:0] out_target_a_y,
  output logic signed [VALUE_WIDTH-1:0] out_target_b_x,
  output logic signed [VALUE_WIDTH-1:0] out_target_b_y,
  output logic signed [VALUE_WIDTH-1:0] out_target_c_x,
  output logic signed [VALUE_WIDTH-1:0] out_target_c_y,
  output logic signed [VALUE_WIDTH-1:0] out_target_d_x,
  output logic signed [VALUE_WIDTH-1:0] out_target_d_y
);
  import tfp_pkg::*;

  localparam int CMD_W = $bits(cmd_ctrl_t) + 2 * VALUE_WIDTH;

  logic                          f_valid, f_ready, b_valid, b_ready;
  cmd_ctrl_t                     f_ctrl, b_ctrl;
  logic signed [VALUE_WIDTH-1:0] f_x, f_y, b_x, b_y;
  logic [CMD_W-1:0]              b_data;
  logic signed [VALUE_WIDTH-1:0] targets [NUM_TARGETS];

  tfp_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd_ctrl   (f_ctrl),
    .cmd_x      (f_x),
    .cmd_y      (f_y)
  );

  tfp_queue #(.WIDTH(CMD_W), .DEPTH(2)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctrl, f_x, f_y}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  assign b_ctrl = b_data[CMD_W-1 -: $bits(cmd_ctrl_t)];
  assign b_x    = b_data[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
  assign b_y    = b_data[VALUE_WIDTH-1:0];

  tfp_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (b_valid),
    .cmd_ready        (b_ready),
    .cmd_ctrl         (b_ctrl),
    .cmd_x            (b_x),
    .cmd_y            (b_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_was_clear    (out_was_clear),
    .out_updated_pair (out_updated_pair),
    .out_targets      (targets)
  );

  assign out_target_a_x = targets[0];
  assign out_target_a_y = targets[1];
  assign out_target_b_x = targets[2];
  assign out_target_b_y = targets[3];
  assign out_target_c_x = targets[4];
  assign out_target_c_y = targets[5];
  assign out_target_d_x = targets[6];
  assign out_target_d_y = targets[7];

endmodule

// ===== bench/tb.sv =====
module tb;
  import tfp_pkg::*;

  localparam int VW        = 16;
  localparam int MAG_LIMIT = 1 << (VW - 1);

  // Parser phases, mirrored from the block's frame grammar
  typedef enum logic [3:0] {
    ST_HUNT, ST_GOT_E, ST_GOT_EC, ST_AFTER_LETTER, ST_X_SPACE, ST_X_SIGN,
    ST_X_DIGITS, ST_Y_SPACE, ST_Y_SIGN, ST_Y_DIGITS, ST_SKIP
  } parse_state_t;

  typedef enum logic {MODE_BYTE = 1'b0, MODE_CLEAR = 1'b1} word_mode_t;

  typedef struct packed {
    word_mode_t mode;
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    cmd_ctrl_t                         ctrl;
    logic [NUM_TARGETS-1:0][VW-1:0]    tgt;
  } target_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_was_clear;
  logic [1:0] out_updated_pair;
  logic signed [VW-1:0] out_target_a_x, out_target_a_y, out_target_b_x, out_target_b_y;
  logic signed [VW-1:0] out_target_c_x, out_target_c_y, out_target_d_x, out_target_d_y;

  target_frame_parser #(.VALUE_WIDTH(VW)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_was_clear    (out_was_clear),
    .out_updated_pair (out_updated_pair),
    .out_target_a_x   (out_target_a_x),
    .out_target_a_y   (out_target_a_y),
    .out_target_b_x   (out_target_b_x),
    .out_target_b_y   (out_target_b_y),
    .out_target_c_x   (out_target_c_x),
    .out_target_c_y   (out_target_c_y),
    .out_target_d_x   (out_target_d_x),
    .out_target_d_y   (out_target_d_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Word streams and bookkeeping
  rx_word_t       pending_words[$];
  target_report_t expected_reports[$];
  logic [7:0]     frame_bytes[$];
  int total_words = 0;
  int words_taken = 0;
  int clear_words = 0;
  int frames_checked = 0;
  int clears_checked = 0;
  int fail_count = 0;

  // Shadow parser state
  parse_state_t                   ps = ST_HUNT;
  logic [1:0]                     fr_pair = '0;
  int                             x_mag = 0;
  int                             y_mag = 0;
  bit                             x_neg = 1'b0;
  bit                             y_neg = 1'b0;
  bit                             nums_done = 1'b0;
  logic [NUM_TARGETS-1:0][VW-1:0] tgt_file = '0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 100) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // Accumulate one decimal digit, capped one above the largest positive value
  function automatic int add_digit(input int mag, input logic [7:0] c);
    int v;
    v = mag * 10 + (int'(c) - int'(CH_0));
    return (v > MAG_LIMIT) ? MAG_LIMIT : v;
  endfunction

  function automatic logic [VW-1:0] saturate(input int mag, input bit neg);
    logic [VW-1:0] v;
    if (neg) v = VW'(-mag);
    else v = VW'((mag > MAG_LIMIT - 1) ? MAG_LIMIT - 1 : mag);
    return v;
  endfunction

  function automatic parse_state_t restart(input logic [7:0] c);
    return (c == CH_E) ? ST_GOT_E : ST_HUNT;
  endfunction

  // Advance the shadow parser by one word; returns 1 when a result is due
  function automatic bit predict_word(input rx_word_t w, output target_report_t r);
    logic [7:0] c;
    bit letter;
    bit ok;
    c = w.rx_byte;
    letter = c >= CH_A && c <= CH_D;
    r = '0;
    if (w.mode == MODE_CLEAR) begin
      tgt_file = '0;
      r.ctrl.is_clear = 1'b1;
      r.tgt = tgt_file;
      return 1'b1;
    end
    // closing P once past the pair letter
    if (ps >= ST_AFTER_LETTER && c == CH_P) begin
      ok = nums_done || ps == ST_Y_DIGITS;
      ps = ST_HUNT;
      nums_done = 1'b0;
      if (!ok) return 1'b0;
      tgt_file[{fr_pair, 1'b0}] = saturate(x_mag, x_neg);
      tgt_file[{fr_pair, 1'b1}] = saturate(y_mag, y_neg);
      r.ctrl.pair = fr_pair;
      r.tgt = tgt_file;
      return 1'b1;
    end
    case (ps)
      ST_HUNT: ps = restart(c);
      ST_GOT_E, ST_GOT_EC: begin
        if (letter) begin
          fr_pair = 2'(c - CH_A);
          x_mag = 0;
          x_neg = 1'b0;
          y_mag = 0;
          y_neg = 1'b0;
          nums_done = 1'b0;
          ps = ST_AFTER_LETTER;
        end else if (ps == ST_GOT_E && c == CH_COMMA) begin
          ps = ST_GOT_EC;
        end else begin
          ps = restart(c);
        end
      end
      ST_AFTER_LETTER, ST_X_SPACE: begin
        if (ps == ST_AFTER_LETTER && c == CH_COMMA) ps = ST_X_SPACE;
        else if (is_space(c)) ps = ST_X_SPACE;
        else if (c == CH_PLUS || c == CH_MINUS) begin
          x_neg = (c == CH_MINUS);
          ps = ST_X_SIGN;
        end else if (is_digit(c)) begin
          x_mag = add_digit(0, c);
          ps = ST_X_DIGITS;
        end else ps = ST_SKIP;
      end
      ST_X_SIGN: begin
        if (is_digit(c)) begin
          x_mag = add_digit(0, c);
          ps = ST_X_DIGITS;
        end else ps = ST_SKIP;
      end
      ST_X_DIGITS: begin
        if (is_digit(c)) x_mag = add_digit(x_mag, c);
        else ps = (c == CH_COMMA) ? ST_Y_SPACE : ST_SKIP;
      end
      ST_Y_SPACE: begin
        if (is_space(c)) begin
          // stay
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          y_neg = (c == CH_MINUS);
          ps = ST_Y_SIGN;
        end else if (is_digit(c)) begin
          y_mag = add_digit(0, c);
          ps = ST_Y_DIGITS;
        end else ps = ST_SKIP;
      end
      ST_Y_SIGN: begin
        if (is_digit(c)) begin
          y_mag = add_digit(0, c);
          ps = ST_Y_DIGITS;
        end else ps = ST_SKIP;
      end
      ST_Y_DIGITS: begin
        if (is_digit(c)) y_mag = add_digit(y_mag, c);
        else begin
          nums_done = 1'b1;
          ps = ST_SKIP;
        end
      end
      ST_SKIP: ;
      default: begin
        ps = ST_HUNT;
        nums_done = 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  // Mostly short gaps, some long ones, and calm stretches with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Stimulus builders
  task automatic add_byte(input logic [7:0] b);
    pending_words.push_back('{mode: MODE_BYTE, rx_byte: b});
  endtask

  task automatic add_clear();
    pending_words.push_back('{mode: MODE_CLEAR, rx_byte: 8'($urandom_range(0, 255))});
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  function automatic logic [7:0] random_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 0) ? CH_SPACE : 8'(CH_TAB + k - 1);
  endfunction

  task automatic push_number();
    int kind;
    int v;
    int r;
    string digits;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
      frame_bytes.push_back(random_space());
    r = $urandom_range(0, 3);
    if (r < 2) frame_bytes.push_back(CH_MINUS);
    else if (r == 2) frame_bytes.push_back(CH_PLUS);
    if ($urandom_range(0, 7) == 0) frame_bytes.push_back(CH_0);
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      // long digit runs, mostly well past saturation
      repeat ($urandom_range(6, 11)) frame_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
    end else begin
      if (kind < 4) v = $urandom_range(0, 99);
      else if (kind < 7) v = $urandom_range(0, 32767);
      else if (kind == 8) v = $urandom_range(32768, 999999);
      else begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = 32768;
          2: v = 32769;
          3: v = 65535;
          default: v = 0;
        endcase
      end
      digits = $sformatf("%0d", v);
      foreach (digits[i]) frame_bytes.push_back(digits[i]);
    end
  endtask

  task automatic add_random_frame();
    int r;
    int pos;
    int clear_at;
    logic [7:0] b;
    frame_bytes.delete();
    frame_bytes.push_back(CH_E);
    if ($urandom_range(0, 1)) frame_bytes.push_back(CH_COMMA);
    frame_bytes.push_back(8'(CH_A + $urandom_range(0, 3)));
    if ($urandom_range(0, 1)) frame_bytes.push_back(CH_COMMA);
    push_number();
    frame_bytes.push_back(CH_COMMA);
    push_number();
    // trailing text before the closing P
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom_range(0, 255));
        frame_bytes.push_back((b == CH_P) ? CH_SPACE : b);
      end
    end
    frame_bytes.push_back(CH_P);
    // broken frames: cut short or one byte replaced
    r = $urandom_range(0, 9);
    if (r == 0) begin
      pos = $urandom_range(0, frame_bytes.size() - 2);
      frame_bytes = frame_bytes[0:pos];
      if ($urandom_range(0, 1)) frame_bytes.push_back(CH_P);
    end else if (r == 1) begin
      pos = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[pos] = 8'($urandom_range(0, 255));
    end
    clear_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, frame_bytes.size() - 1) : -1;
    foreach (frame_bytes[i]) begin
      if (i == clear_at) add_clear();
      add_byte(frame_bytes[i]);
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Driver: one word at a time, random gaps between words
  int rx_gap_left = 0;
  int rx_calm = 0;
  rx_word_t nxt_word;
  rx_word_t taken_word;
  target_report_t due_report;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken_word.mode = word_mode_t'(in_mode);
        taken_word.rx_byte = in_rx_byte;
        if (predict_word(taken_word, due_report)) expected_reports.push_back(due_report);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (rx_gap_left > 0) begin
          rx_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          nxt_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt_word.mode;
          in_rx_byte <= nxt_word.rx_byte;
          rx_gap_left = pick_gap(rx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and field-by-field comparison
  int out_stall_left = 0;
  int out_calm = 0;
  target_report_t want;
  logic [NUM_TARGETS-1:0][VW-1:0] got;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_reports.pop_front();
          got = {out_target_d_y, out_target_d_x, out_target_c_y, out_target_c_x,
                 out_target_b_y, out_target_b_x, out_target_a_y, out_target_a_x};
          if (want.ctrl.is_clear) clears_checked++;
          else frames_checked++;
          if (out_was_clear !== want.ctrl.is_clear)
            report_mismatch($sformatf("was_clear %b, expected %b",
                                      out_was_clear, want.ctrl.is_clear));
          if (out_updated_pair !== want.ctrl.pair)
            report_mismatch($sformatf("updated_pair %0d, expected %0d",
                                      out_updated_pair, want.ctrl.pair));
          for (int k = 0; k < NUM_TARGETS; k++) begin
            if (got[k] !== want.tgt[k])
              report_mismatch($sformatf("target %0d is %0d, expected %0d",
                                        k, $signed(got[k]), $signed(want.tgt[k])));
          end
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall_left = ($urandom_range(0, 2) == 0) ? pick_gap(out_calm) : 0;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and end of run
  int random_start;
  int pick;

  initial begin
    // commas optional, signs, extremes, saturation, whitespace, trailing text
    add_text("EA,1,-2P");
    add_text("E,B,+32767,-32768P");
    add_text("EC99999,-99999P");
    add_text("ED \t7,\n8 xyzP");
    add_clear();
    // bad start re-examined as a new E
    add_text("EE,C3,4P");
    // bad payloads: early P, missing comma, E inside frame
    add_text("EA,PEA1;2PEA1,E2P");
    // clear in the middle of a frame
    add_text("EB1,");
    add_clear();
    add_text("2PEA0,0P");

    random_start = pending_words.size();
    while (pending_words.size() - random_start < 1600) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) add_random_frame();
      else if (pick < 93) add_noise();
      else add_clear();
    end
    total_words = pending_words.size();
    foreach (pending_words[i]) if (pending_words[i].mode == MODE_CLEAR) clear_words++;

    while (words_taken != total_words || expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Fed %0d words (%0d clears) through the parser.", total_words, clear_words);
    $display("Checked %0d frame results and %0d clear results.", frames_checked,
             clears_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== target_frame_parser.f =====
rtl/core/tfp_pkg.sv
rtl/core/tfp_queue.sv
rtl/core/tfp_front.sv
rtl/core/tfp_back.sv
rtl/core/target_frame_parser.sv
bench/tb.sv
